// ===== rtl/msa_pkg.sv =====
// Shared types, widths and a helper function for the six-axis moving average.
// No dependencies; every other file in rtl/ refers to this package by scope.
package msa_pkg;

    localparam int AXES       = 6;
    localparam int SAMPLE_W   = 16;
    localparam int MEAN_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int WINDOW_DEF = 50;

    typedef logic [AXES-1:0][SAMPLE_W-1:0] frame_t;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
        logic out_load;
    } pipe_ctrl_t;

    // Running sum of WINDOW samples of SAMPLE_W bits, signed.
    function automatic int sum_width(input int window);
        return $clog2(window) + SAMPLE_W;
    endfunction

endpackage

// ===== rtl/msa_raw_if.sv =====
// Input channel: one frame of six raw sensor readings, valid/ready handshake.
// Depends on msa_pkg for field widths.
interface msa_raw_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msa_pkg::SAMPLE_W-1:0]   accel_x_raw;
    logic signed [msa_pkg::SAMPLE_W-1:0]   accel_y_raw;
    logic signed [msa_pkg::SAMPLE_W-1:0]   accel_z_raw;
    logic signed [msa_pkg::SAMPLE_W-1:0]   gyro_x_raw;
    logic signed [msa_pkg::SAMPLE_W-1:0]   gyro_y_raw;
    logic signed [msa_pkg::SAMPLE_W-1:0]   gyro_z_raw;

    modport source (
        output valid, accel_x_raw, accel_y_raw, accel_z_raw,
               gyro_x_raw, gyro_y_raw, gyro_z_raw,
        input  ready
    );

    modport sink (
        input  valid, accel_x_raw, accel_y_raw, accel_z_raw,
               gyro_x_raw, gyro_y_raw, gyro_z_raw,
        output ready
    );
endinterface

// ===== rtl/msa_mean_if.sv =====
// Output channel: one frame of six windowed means, valid/ready handshake.
// Depends on msa_pkg for field widths.
interface msa_mean_if;
    logic                                valid;
    logic                                ready;
    logic signed [msa_pkg::MEAN_W-1:0]   accel_x_mean;
    logic signed [msa_pkg::MEAN_W-1:0]   accel_y_mean;
    logic signed [msa_pkg::MEAN_W-1:0]   accel_z_mean;
    logic signed [msa_pkg::MEAN_W-1:0]   gyro_x_mean;
    logic signed [msa_pkg::MEAN_W-1:0]   gyro_y_mean;
    logic signed [msa_pkg::MEAN_W-1:0]   gyro_z_mean;

    modport source (
        output valid, accel_x_mean, accel_y_mean, accel_z_mean,
               gyro_x_mean, gyro_y_mean, gyro_z_mean,
        input  ready
    );

    modport sink (
        input  valid, accel_x_mean, accel_y_mean, accel_z_mean,
               gyro_x_mean, gyro_y_mean, gyro_z_mean,
        output ready
    );
endinterface

// ===== rtl/msa_window_ram.sv =====
// Sample window store: one synchronous RAM of frames, per-entry valid bits
// cleared at reset, and write-to-read forwarding. Depends on msa_pkg.
module msa_window_ram #(
    parameter int WINDOW = msa_pkg::WINDOW_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        rd_en,
    input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] rd_addr,
    input  logic                                        wr_en,
    input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] wr_addr,
    input  msa_pkg::frame_t                             wr_data,
    output msa_pkg::frame_t                             old_data
);

    msa_pkg::frame_t   mem [WINDOW];
    msa_pkg::frame_t   rd_data_reg;
    msa_pkg::frame_t   fwd_data_reg;
    logic [WINDOW-1:0] vld_reg;
    logic              rd_vld_reg;
    logic              hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
                hit_reg    <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Take the same-cycle write, else stored data, else a cleared entry.
    always_comb
    begin
        if (hit_reg)
        begin
            old_data = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            old_data = rd_data_reg;
        end
        else
        begin
            old_data = '0;
        end
    end

endmodule

// ===== rtl/msa_accum.sv =====
// Running sums: subtract the oldest sample, add the new one, per axis.
// Depends on msa_pkg.
module msa_accum #(
    parameter int WINDOW = msa_pkg::WINDOW_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               upd,
    input  msa_pkg::frame_t                                    new_frame,
    input  msa_pkg::frame_t                                    old_frame,
    output logic signed [msa_pkg::sum_width(WINDOW)-1:0]       sum_next [msa_pkg::AXES]
);

    localparam int SW = msa_pkg::sum_width(WINDOW);

    logic signed [SW-1:0] sum_reg [msa_pkg::AXES];

    always_comb
    begin
        for (int a = 0; a < msa_pkg::AXES; a++)
        begin
            sum_next[a] = sum_reg[a] + SW'(signed'(new_frame[a]))
                                     - SW'(signed'(old_frame[a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < msa_pkg::AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (upd)
        begin
            for (int a = 0; a < msa_pkg::AXES; a++)
            begin
                sum_reg[a] <= sum_next[a];
            end
        end
    end

endmodule

// ===== rtl/msa_divider.sv =====
// Floored division of sum * 256 by WINDOW via reciprocal multiply, per axis.
// Two register stages plus the output register. Depends on msa_pkg.
module msa_divider #(
    parameter int WINDOW = msa_pkg::WINDOW_DEF
) (
    input  logic                                         clk,
    input  msa_pkg::pipe_ctrl_t                          ctrl,
    input  logic signed [msa_pkg::sum_width(WINDOW)-1:0] sum_next [msa_pkg::AXES],
    output logic        [msa_pkg::MEAN_W-1:0]            mean [msa_pkg::AXES]
);

    localparam int SW    = msa_pkg::sum_width(WINDOW);
    localparam int NW    = SW + msa_pkg::FRAC_W;
    localparam int N     = NW - 1;
    localparam int LOG_W = $clog2(WINDOW);
    localparam int MW    = N + 1;
    localparam int PW    = N + MW;
    localparam int SH    = N + LOG_W;
    localparam longint unsigned MUL_L =
        ((64'd1 << SH) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [MW-1:0] MUL = MW'(MUL_L);

    logic          neg2_reg [msa_pkg::AXES];
    logic [N-1:0]  mag_reg  [msa_pkg::AXES];
    logic          neg3_reg [msa_pkg::AXES];
    logic [PW-1:0] prod_reg [msa_pkg::AXES];

    for (genvar a = 0; a < msa_pkg::AXES; a++)
    begin : g_lane
        logic [NW-1:0]              num;
        logic [NW-1:0]              mag_full;
        logic [msa_pkg::MEAN_W-1:0] quo;

        // Negative values: floor(x / W) == ~floor(~x / W).
        assign num      = {sum_next[a], msa_pkg::FRAC_W'(0)};
        assign mag_full = sum_next[a][SW-1] ? ~num : num;
        assign quo      = prod_reg[a][SH +: msa_pkg::MEAN_W];

        always_ff @(posedge clk)
        begin
            if (ctrl.s2_load)
            begin
                neg2_reg[a] <= sum_next[a][SW-1];
                mag_reg[a]  <= mag_full[N-1:0];
            end
            if (ctrl.s3_load)
            begin
                neg3_reg[a] <= neg2_reg[a];
                prod_reg[a] <= PW'(mag_reg[a]) * PW'(MUL);
            end
            if (ctrl.out_load)
            begin
                mean[a] <= neg3_reg[a] ? ~quo : quo;
            end
        end
    end

endmodule

// ===== rtl/six_axis_moving_average.sv =====
// Six-axis boxcar moving average: top level with pipeline control.
// Depends on msa_pkg, msa_raw_if, msa_mean_if, msa_window_ram, msa_accum,
// msa_divider.
//
//   channel     | role  | payload
//   ------------+-------+---------------------------------------------
//   raw_frame   | sink  | six signed 16-bit readings (accel x/y/z, gyro x/y/z)
//   mean_frame  | source| six signed 24-bit means, 8 fraction bits
//
// One frame per cycle sustained while mean_frame is ready; a mean frame
// follows its raw frame through the RAM read at the transfer, then the sum
// update, the multiply and the output register.
// The window RAM port and the per-cycle running-sum update set that rate.
// Reset clears the sums, the write position and the per-entry valid bits.
// A stall on mean_frame backs up through the output, s3, s2 and s1 stages
// before raw_frame drops ready; bubbles are squeezed out.
module six_axis_moving_average #(
    parameter int WINDOW = msa_pkg::WINDOW_DEF
) (
    input logic         clk,
    input logic         rst_n,
    msa_raw_if.sink     raw_frame,
    msa_mean_if.source  mean_frame
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = msa_pkg::sum_width(WINDOW);

    logic                s1_vld_reg;
    logic                s2_vld_reg;
    logic                s3_vld_reg;
    logic                out_vld_reg;
    logic [AW-1:0]       wr_pos_reg;
    logic [AW-1:0]       wr_pos_next;
    logic [AW-1:0]       s1_pos_reg;
    msa_pkg::frame_t     s1_frame_reg;
    msa_pkg::frame_t     raw_pack;
    msa_pkg::frame_t     old_frame;
    msa_pkg::pipe_ctrl_t ctrl;
    logic signed [SW-1:0]           sum_next [msa_pkg::AXES];
    logic [msa_pkg::MEAN_W-1:0]     mean [msa_pkg::AXES];

    logic out_room;
    logic s3_room;
    logic s2_room;
    logic s1_room;
    logic s1_go;
    logic accept;

    assign out_room = !out_vld_reg || mean_frame.ready;
    assign s3_room  = !s3_vld_reg || out_room;
    assign s2_room  = !s2_vld_reg || s3_room;
    assign s1_room  = !s1_vld_reg || s2_room;
    assign s1_go    = s1_vld_reg && s2_room;
    assign accept   = raw_frame.valid && s1_room;

    assign raw_frame.ready = s1_room;

    assign ctrl.s2_load  = s1_go;
    assign ctrl.s3_load  = s2_vld_reg && s3_room;
    assign ctrl.out_load = s3_vld_reg && out_room;

    assign wr_pos_next = (wr_pos_reg == AW'(WINDOW - 1)) ? '0 : wr_pos_reg + AW'(1);

    always_comb
    begin
        raw_pack[0] = raw_frame.accel_x_raw;
        raw_pack[1] = raw_frame.accel_y_raw;
        raw_pack[2] = raw_frame.accel_z_raw;
        raw_pack[3] = raw_frame.gyro_x_raw;
        raw_pack[4] = raw_frame.gyro_y_raw;
        raw_pack[5] = raw_frame.gyro_z_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            wr_pos_reg  <= '0;
        end
        else
        begin
            if (out_room)
            begin
                out_vld_reg <= s3_vld_reg;
            end
            if (s3_room)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (s2_room)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s1_room)
            begin
                s1_vld_reg <= raw_frame.valid;
            end
            if (accept)
            begin
                wr_pos_reg <= wr_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frame_reg <= raw_pack;
            s1_pos_reg   <= wr_pos_reg;
        end
    end

    msa_window_ram #(
        .WINDOW (WINDOW)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (wr_pos_reg),
        .wr_en    (s1_go),
        .wr_addr  (s1_pos_reg),
        .wr_data  (s1_frame_reg),
        .old_data (old_frame)
    );

    msa_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (s1_go),
        .new_frame (s1_frame_reg),
        .old_frame (old_frame),
        .sum_next  (sum_next)
    );

    msa_divider #(
        .WINDOW (WINDOW)
    ) u_div (
        .clk      (clk),
        .ctrl     (ctrl),
        .sum_next (sum_next),
        .mean     (mean)
    );

    assign mean_frame.valid        = out_vld_reg;
    assign mean_frame.accel_x_mean = mean[0];
    assign mean_frame.accel_y_mean = mean[1];
    assign mean_frame.accel_z_mean = mean[2];
    assign mean_frame.gyro_x_mean  = mean[3];
    assign mean_frame.gyro_y_mean  = mean[4];
    assign mean_frame.gyro_z_mean  = mean[5];

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pos_reg <= AW'(WINDOW - 1))
        else $error("write position beyond window");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(wr_pos_reg))
        else $error("write position moved without a transfer");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !(out_vld_reg && mean_frame.ready)) |=>
        ($countones({s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg}) ==
         $past($countones({s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg})) + 1))
        else $error("frame lost or duplicated in pipeline");

endmodule
